@@ rtl/rhslp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rhslp_pkg;

  // table geometry
  localparam int TABLE_SIZE        = 769;
  localparam int PROBE_STEP        = 193;
  localparam int KEY_FRACTION_BITS = 16;

  localparam int KEY_W   = KEY_FRACTION_BITS + 1;
  localparam int SLOT_W  = $clog2(TABLE_SIZE);
  localparam int COUNT_W = $clog2(TABLE_SIZE + 1);
  localparam int PROD_W  = KEY_W + SLOT_W;
  localparam int HASH_W  = PROD_W - KEY_FRACTION_BITS;
  localparam int ENTRY_W = KEY_W + 1;

  // fixed result field widths
  localparam int OUT_STATUS_W = 2;
  localparam int OUT_IDX_W    = 10;
  localparam int OUT_FILL_W   = 10;

  // 4*n > 3*T  <=>  n > floor(3*T/4)
  localparam int LOAD_LIMIT = (3 * TABLE_SIZE) / 4;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef enum logic [OUT_STATUS_W-1:0] {
    STATUS_NEW     = 2'd0,
    STATUS_PRESENT = 2'd1,
    STATUS_ABSENT  = 2'd2,
    STATUS_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE
  } state_t;

  typedef struct packed {
    logic clear;    // write an empty entry at the sweep pointer
    logic load;     // capture the input item
    logic start;    // reduce hash to start slot, issue first read
    logic advance;  // step to next slot, issue its read
    logic finish;   // retire the item into the output register
  } cmd_t;

  typedef struct packed {
    logic clear_last;  // sweep pointer at the last slot
    logic probe_end;   // current slot ends the probe
    logic out_free;    // output register can take a result
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/rank_hash_set_linear_probe_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Open-addressing set of rank keys (unsigned, 16 fraction bits) in a 769-slot
// table with linear probing. Each item inserts (func 0) or looks up (func 1)
// a key; the probe starts at ((key*769)>>16) mod 769 and steps by 193 mod 769,
// ending at the key, at an empty slot, or after all 769 slots. One result
// item per input item: status (new / present / absent / full), the slot where
// the probe ended, the occupancy after the item, and an over-load flag set
// once occupancy exceeds three quarters of the table. The table never grows.
// After reset the store is swept empty, one slot per cycle, with in_ready low.
// Once an item is accepted, its hash is reduced to the start slot, then the n
// probed slots (1..769) are read one after another through the single read
// port of the key store; the result is registered when the probe ends. The next
// item can be accepted in the cycle in which that result is valid, so a new item
// is not taken before the last one is retired; a result waiting in the output
// register stalls only the end of the following item's probe.

module rank_hash_set_linear_probe_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 in_func,
  input  wire logic [rhslp_pkg::KEY_W-1:0]          in_rank_key,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic      [rhslp_pkg::OUT_STATUS_W-1:0]   out_status,
  output logic      [rhslp_pkg::OUT_IDX_W-1:0]      out_slot_index,
  output logic      [rhslp_pkg::OUT_FILL_W-1:0]     out_fill_count,
  output logic                                      out_over_load
);

  rhslp_pkg::cmd_t cmd;
  rhslp_pkg::sts_t sts;

  // sequencer: clear sweep, accept, hash, probe loop
  rhslp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // key store, probe address arithmetic, occupancy and result register
  rhslp_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_func        (in_func),
    .in_rank_key    (in_rank_key),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_slot_index (out_slot_index),
    .out_fill_count (out_fill_count),
    .out_over_load  (out_over_load)
  );

endmodule

`default_nettype wire

@@ rtl/rhslp_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rhslp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/rhslp_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rhslp_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire rhslp_pkg::sts_t sts,
  output rhslp_pkg::cmd_t      cmd
);

  rhslp_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rhslp_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      rhslp_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_nxt = rhslp_pkg::ST_IDLE;
        end
      end
      rhslp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = rhslp_pkg::ST_HASH;
        end
      end
      rhslp_pkg::ST_HASH: begin
        cmd.start = 1'b1;
        state_nxt = rhslp_pkg::ST_PROBE;
      end
      rhslp_pkg::ST_PROBE: begin
        if (!sts.probe_end) begin
          cmd.advance = 1'b1;
        end else if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = rhslp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rhslp_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/rhslp_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rhslp_dp (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire rhslp_pkg::cmd_t                        cmd,
  output rhslp_pkg::sts_t                             sts,
  input  wire logic                                   in_func,
  input  wire logic [rhslp_pkg::KEY_W-1:0]            in_rank_key,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic      [rhslp_pkg::OUT_STATUS_W-1:0]     out_status,
  output logic      [rhslp_pkg::OUT_IDX_W-1:0]        out_slot_index,
  output logic      [rhslp_pkg::OUT_FILL_W-1:0]       out_fill_count,
  output logic                                        out_over_load
);

  localparam logic [rhslp_pkg::SLOT_W-1:0] LAST_SLOT =
    rhslp_pkg::SLOT_W'(rhslp_pkg::TABLE_SIZE - 1);
  localparam logic [rhslp_pkg::SLOT_W:0] SIZE_EXT =
    (rhslp_pkg::SLOT_W + 1)'(rhslp_pkg::TABLE_SIZE);
  localparam logic [rhslp_pkg::SLOT_W:0] STEP_EXT =
    (rhslp_pkg::SLOT_W + 1)'(rhslp_pkg::PROBE_STEP % rhslp_pkg::TABLE_SIZE);
  localparam logic [rhslp_pkg::HASH_W-1:0] SIZE_HASH =
    rhslp_pkg::HASH_W'(rhslp_pkg::TABLE_SIZE);
  localparam logic [rhslp_pkg::COUNT_W-1:0] SIZE_CNT =
    rhslp_pkg::COUNT_W'(rhslp_pkg::TABLE_SIZE);
  localparam logic [rhslp_pkg::COUNT_W-1:0] LIMIT_CNT =
    rhslp_pkg::COUNT_W'(rhslp_pkg::LOAD_LIMIT);

  logic                              func_r;
  logic [rhslp_pkg::KEY_W-1:0]       key_r;
  logic [rhslp_pkg::PROD_W-1:0]      prod_r;
  logic [rhslp_pkg::SLOT_W-1:0]      idx_r;
  logic [rhslp_pkg::COUNT_W-1:0]     att_r;
  logic [rhslp_pkg::COUNT_W-1:0]     count_r;
  logic [rhslp_pkg::SLOT_W-1:0]      clr_r;
  logic                              out_valid_r;
  rhslp_pkg::status_t                out_status_r;
  logic [rhslp_pkg::OUT_IDX_W-1:0]   out_slot_r;
  logic [rhslp_pkg::OUT_FILL_W-1:0]  out_fill_r;
  logic                              out_over_r;

  logic [rhslp_pkg::HASH_W-1:0]      hash;
  logic [rhslp_pkg::SLOT_W-1:0]      start_slot;
  logic [rhslp_pkg::SLOT_W:0]        step_sum;
  logic [rhslp_pkg::SLOT_W-1:0]      idx_step;
  logic                              ram_we;
  logic [rhslp_pkg::SLOT_W-1:0]      ram_waddr;
  logic [rhslp_pkg::ENTRY_W-1:0]     ram_wdata;
  logic [rhslp_pkg::SLOT_W-1:0]      ram_raddr;
  logic [rhslp_pkg::ENTRY_W-1:0]     ram_rdata;
  logic                              slot_full;
  logic                              key_match;
  logic                              store_new;
  logic [rhslp_pkg::COUNT_W-1:0]     count_nxt;
  rhslp_pkg::status_t                status;

  // start slot: hash < 2*T, so one conditional subtract
  assign hash       = prod_r[rhslp_pkg::PROD_W-1:rhslp_pkg::KEY_FRACTION_BITS];
  assign start_slot = (hash >= SIZE_HASH) ? rhslp_pkg::SLOT_W'(hash - SIZE_HASH)
                                          : rhslp_pkg::SLOT_W'(hash);

  assign step_sum = {1'b0, idx_r} + STEP_EXT;
  assign idx_step = (step_sum >= SIZE_EXT) ? rhslp_pkg::SLOT_W'(step_sum - SIZE_EXT)
                                           : rhslp_pkg::SLOT_W'(step_sum);

  // entry = {valid, key}
  assign slot_full = ram_rdata[rhslp_pkg::ENTRY_W-1];
  assign key_match = slot_full && (ram_rdata[rhslp_pkg::KEY_W-1:0] == key_r);
  assign store_new = cmd.finish && !slot_full && (func_r == rhslp_pkg::FUNC_INSERT);

  always_comb begin
    if (!slot_full) begin
      status = (func_r == rhslp_pkg::FUNC_INSERT) ? rhslp_pkg::STATUS_NEW
                                                  : rhslp_pkg::STATUS_ABSENT;
    end else if (key_match) begin
      status = rhslp_pkg::STATUS_PRESENT;
    end else begin
      status = rhslp_pkg::STATUS_FULL;
    end
  end

  assign count_nxt = store_new ? count_r + 1'b1 : count_r;

  assign ram_we    = cmd.clear || store_new;
  assign ram_waddr = cmd.clear ? clr_r : idx_r;
  assign ram_wdata = cmd.clear ? '0 : {1'b1, key_r};

  always_comb begin
    if (cmd.start) begin
      ram_raddr = start_slot;
    end else if (cmd.advance) begin
      ram_raddr = idx_step;
    end else begin
      ram_raddr = idx_r;
    end
  end

  rhslp_ram #(
    .WIDTH (rhslp_pkg::ENTRY_W),
    .DEPTH (rhslp_pkg::TABLE_SIZE)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    sts.clear_last = (clr_r == LAST_SLOT);
    sts.probe_end  = !slot_full || key_match || (att_r == SIZE_CNT);
    sts.out_free   = !out_valid_r || out_ready;
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      key_r  <= in_rank_key;
      prod_r <= rhslp_pkg::PROD_W'(in_rank_key) *
                rhslp_pkg::PROD_W'(rhslp_pkg::TABLE_SIZE);
    end
    if (cmd.start) begin
      idx_r <= start_slot;
    end else if (cmd.advance) begin
      idx_r <= idx_step;
    end
    if (cmd.finish) begin
      out_status_r <= status;
      out_slot_r   <= rhslp_pkg::OUT_IDX_W'(idx_r);
      out_fill_r   <= rhslp_pkg::OUT_FILL_W'(count_nxt);
      out_over_r   <= (count_nxt > LIMIT_CNT);
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      att_r       <= '0;
      count_r     <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        att_r <= rhslp_pkg::COUNT_W'(1);
      end else if (cmd.advance) begin
        att_r <= att_r + 1'b1;
      end
      count_r <= count_nxt;
      if (cmd.clear) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_index = out_slot_r;
  assign out_fill_count = out_fill_r;
  assign out_over_load  = out_over_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= SIZE_CNT)
    else $error("occupancy above table size");

  a_att_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.advance |-> (att_r < SIZE_CNT) && (idx_r <= LAST_SLOT))
    else $error("probe ran past table size");

  a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
    store_new |=> count_r == $past(count_r) + 1'b1)
    else $error("new key not counted");

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> sts.probe_end && sts.out_free)
    else $error("item retired before probe end or over held result");

endmodule

`default_nettype wire
